// File: rtl/mhpq_pkg.sv
`timescale 1ns / 1ps

package mhpq_pkg;

    // heap size and derived widths
    localparam int CAPACITY = 64;
    localparam int KEY_W    = 8;
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int POS_W    = CNT_W + 1;
    localparam int ADDR_W   = $clog2(CAPACITY);
    localparam int OCNT_W   = 7;

    // command codes carried on the input tuser
    localparam logic CMD_INSERT  = 1'b0;
    localparam logic CMD_EXTRACT = 1'b1;

    // result status codes
    localparam logic [1:0] STATUS_OK       = 2'd0;
    localparam logic [1:0] STATUS_OVERFLOW = 2'd1;
    localparam logic [1:0] STATUS_EMPTY    = 2'd2;

    localparam logic signed [KEY_W-1:0] EMPTY_KEY = -8'sd1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EX_LOAD,
        ST_UP_RD,
        ST_UP_CMP,
        ST_DN_RD,
        ST_DN_CMP,
        ST_DONE
    } state_t;

    // one-based heap position to zero-based ram address
    function automatic logic [ADDR_W-1:0] addr_of(input logic [POS_W-1:0] pos);
        logic [POS_W-1:0] zb;
        zb = pos - POS_W'(1);
        return zb[ADDR_W-1:0];
    endfunction

endpackage

// File: rtl/mhpq_ram.sv
`timescale 1ns / 1ps

module mhpq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr_a,
    output logic [WIDTH-1:0]         rdata_a,
    input  logic [$clog2(DEPTH)-1:0] raddr_b,
    output logic [WIDTH-1:0]         rdata_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    // one write port, two registered read ports
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_a <= mem[raddr_a];
        rdata_b <= mem[raddr_b];
    end

endmodule

// File: rtl/min_heap_priority_queue.sv
`timescale 1ns / 1ps

// Binary min-heap priority queue of signed 8-bit keys.
// Input channel s_*: s_tuser is the command (0 insert, 1 extract minimum),
// s_tdata the key to insert. One input transfer gives exactly one result.
// Output channel m_*: m_tdata carries the extracted key (-1 when empty, 0 on
// insert) and the entry count after the operation, m_tuser the status
// (0 ok, 1 overflow on insert, 2 empty on extract).
// The heap lives in a two-read, one-write ram; one compare unit walks the
// tree one level at a time, each level a ram read state, then a compare and
// write state. An insert climbs at most 6 levels at 64 entries; once the key
// reaches the root it is written there without a compare. An extract first
// loads the root and the last entry, then descends, or goes straight to the
// done state when it removes the only entry. Overflow and empty cases go
// from idle straight to the done state.
// Only one operation is in flight: s_tready is high only while idle, so the
// next transfer is taken at the earliest in the cycle in which the result is
// presented.
// The result is held in an output register; when the receiver stalls, the
// next result waits in the sequencer and no new input is taken.
// Reset empties the heap at once (count cleared, no ram sweep) and drops any
// pending result.

module min_heap_priority_queue (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] key_in
    input  logic        s_tuser,   // [0] command
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [7:0] key_out, [14:8] entry_count, [15] zero
    output logic [1:0]  m_tuser    // [1:0] status
);

    localparam int KEY_W  = mhpq_pkg::KEY_W;
    localparam int CNT_W  = mhpq_pkg::CNT_W;
    localparam int POS_W  = mhpq_pkg::POS_W;
    localparam int ADDR_W = mhpq_pkg::ADDR_W;
    localparam int OCNT_W = mhpq_pkg::OCNT_W;

    mhpq_pkg::state_t state_reg, state_next;

    logic [CNT_W-1:0]        count_reg, count_next;
    logic [POS_W-1:0]        pos_reg, pos_next;
    logic signed [KEY_W-1:0] key_reg, key_next;
    logic signed [KEY_W-1:0] res_key_reg, res_key_next;
    logic [1:0]              res_status_reg, res_status_next;

    logic                    out_valid_reg, out_valid_next;
    logic signed [KEY_W-1:0] out_key_reg, out_key_next;
    logic [1:0]              out_status_reg, out_status_next;
    logic [OCNT_W-1:0]       out_count_reg, out_count_next;

    logic              ram_we;
    logic [ADDR_W-1:0] ram_waddr;
    logic [KEY_W-1:0]  ram_wdata;
    logic [ADDR_W-1:0] ram_raddr_a;
    logic [ADDR_W-1:0] ram_raddr_b;
    logic [KEY_W-1:0]  ram_rdata_a;
    logic [KEY_W-1:0]  ram_rdata_b;

    logic                    in_xfer;
    logic                    out_free;
    logic [POS_W-1:0]        parent_pos;
    logic [POS_W-1:0]        child1_pos;
    logic [POS_W-1:0]        child2_pos;
    logic                    child1_ok;
    logic                    child2_ok;
    logic                    take_second;
    logic [POS_W-1:0]        best_pos;
    logic signed [KEY_W-1:0] best_key;
    logic signed [KEY_W-1:0] rd_a;
    logic signed [KEY_W-1:0] rd_b;

    mhpq_ram #(
        .WIDTH (KEY_W),
        .DEPTH (mhpq_pkg::CAPACITY)
    ) u_heap_ram (
        .clk     (clk),
        .we      (ram_we),
        .waddr   (ram_waddr),
        .wdata   (ram_wdata),
        .raddr_a (ram_raddr_a),
        .rdata_a (ram_rdata_a),
        .raddr_b (ram_raddr_b),
        .rdata_b (ram_rdata_b)
    );

    assign s_tready = (state_reg == mhpq_pkg::ST_IDLE);
    assign in_xfer  = s_tvalid && s_tready;
    assign out_free = !out_valid_reg || m_tready;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {1'b0, out_count_reg, out_key_reg};
    assign m_tuser  = out_status_reg;

    // tree neighbors of the hole and the shared compare
    assign rd_a        = $signed(ram_rdata_a);
    assign rd_b        = $signed(ram_rdata_b);
    assign parent_pos  = pos_reg >> 1;
    assign child1_pos  = {pos_reg[POS_W-2:0], 1'b0};
    assign child2_pos  = {pos_reg[POS_W-2:0], 1'b1};
    assign child1_ok   = (child1_pos <= POS_W'(count_reg));
    assign child2_ok   = (child2_pos <= POS_W'(count_reg));
    assign take_second = child2_ok && (rd_b < rd_a);
    assign best_pos    = take_second ? child2_pos : child1_pos;
    assign best_key    = take_second ? rd_b : rd_a;

    // sequencer: next state, ram control, result
    always_comb
    begin
        state_next      = state_reg;
        count_next      = count_reg;
        pos_next        = pos_reg;
        key_next        = key_reg;
        res_key_next    = res_key_reg;
        res_status_next = res_status_reg;
        out_valid_next  = out_valid_reg && !m_tready;
        out_key_next    = out_key_reg;
        out_status_next = out_status_reg;
        out_count_next  = out_count_reg;
        ram_we          = 1'b0;
        ram_waddr       = '0;
        ram_wdata       = key_reg;
        ram_raddr_a     = '0;
        ram_raddr_b     = '0;

        unique case (state_reg)
            mhpq_pkg::ST_IDLE:
            begin
                // root and last entry are fetched in case this is an extract
                ram_raddr_a = '0;
                ram_raddr_b = ADDR_W'(count_reg - CNT_W'(1));
                if (in_xfer)
                begin
                    res_status_next = mhpq_pkg::STATUS_OK;
                    res_key_next    = '0;
                    if (s_tuser == mhpq_pkg::CMD_INSERT)
                    begin
                        if (count_reg >= CNT_W'(mhpq_pkg::CAPACITY))
                        begin
                            res_status_next = mhpq_pkg::STATUS_OVERFLOW;
                            state_next      = mhpq_pkg::ST_DONE;
                        end
                        else
                        begin
                            count_next = count_reg + CNT_W'(1);
                            pos_next   = POS_W'(count_reg) + POS_W'(1);
                            key_next   = $signed(s_tdata);
                            state_next = mhpq_pkg::ST_UP_RD;
                        end
                    end
                    else
                    begin
                        if (count_reg == '0)
                        begin
                            res_key_next    = mhpq_pkg::EMPTY_KEY;
                            res_status_next = mhpq_pkg::STATUS_EMPTY;
                            state_next      = mhpq_pkg::ST_DONE;
                        end
                        else
                        begin
                            count_next = count_reg - CNT_W'(1);
                            state_next = mhpq_pkg::ST_EX_LOAD;
                        end
                    end
                end
            end

            mhpq_pkg::ST_EX_LOAD:
            begin
                // root goes out, last entry becomes the moving key at the root
                res_key_next = rd_a;
                key_next     = rd_b;
                pos_next     = POS_W'(1);
                state_next   = (count_reg == '0) ? mhpq_pkg::ST_DONE : mhpq_pkg::ST_DN_RD;
            end

            mhpq_pkg::ST_UP_RD:
            begin
                if (pos_reg == POS_W'(1))
                begin
                    ram_we     = 1'b1;
                    ram_waddr  = mhpq_pkg::addr_of(pos_reg);
                    ram_wdata  = key_reg;
                    state_next = mhpq_pkg::ST_DONE;
                end
                else
                begin
                    ram_raddr_a = mhpq_pkg::addr_of(parent_pos);
                    state_next  = mhpq_pkg::ST_UP_CMP;
                end
            end

            mhpq_pkg::ST_UP_CMP:
            begin
                // parent moves down into the hole while strictly greater
                ram_we    = 1'b1;
                ram_waddr = mhpq_pkg::addr_of(pos_reg);
                if (rd_a > key_reg)
                begin
                    ram_wdata  = ram_rdata_a;
                    pos_next   = parent_pos;
                    state_next = mhpq_pkg::ST_UP_RD;
                end
                else
                begin
                    ram_wdata  = key_reg;
                    state_next = mhpq_pkg::ST_DONE;
                end
            end

            mhpq_pkg::ST_DN_RD:
            begin
                ram_raddr_a = mhpq_pkg::addr_of(child1_pos);
                ram_raddr_b = mhpq_pkg::addr_of(child2_pos);
                state_next  = mhpq_pkg::ST_DN_CMP;
            end

            mhpq_pkg::ST_DN_CMP:
            begin
                // smaller child moves up while the key is strictly greater
                ram_we    = 1'b1;
                ram_waddr = mhpq_pkg::addr_of(pos_reg);
                if (child1_ok && (key_reg > best_key))
                begin
                    ram_wdata  = best_key;
                    pos_next   = best_pos;
                    state_next = mhpq_pkg::ST_DN_RD;
                end
                else
                begin
                    ram_wdata  = key_reg;
                    state_next = mhpq_pkg::ST_DONE;
                end
            end

            mhpq_pkg::ST_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_key_next    = res_key_reg;
                    out_status_next = res_status_reg;
                    out_count_next  = OCNT_W'(count_reg);
                    state_next      = mhpq_pkg::ST_IDLE;
                end
            end

            default:
            begin
                state_next = mhpq_pkg::ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= mhpq_pkg::ST_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        pos_reg        <= pos_next;
        key_reg        <= key_next;
        res_key_reg    <= res_key_next;
        res_status_reg <= res_status_next;
        out_key_reg    <= out_key_next;
        out_status_reg <= out_status_next;
        out_count_reg  <= out_count_next;
    end

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(mhpq_pkg::CAPACITY))
        else $error("entry count above capacity");

    a_hole_in_heap: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == mhpq_pkg::ST_UP_CMP || state_reg == mhpq_pkg::ST_DN_CMP)
        |-> (pos_reg >= POS_W'(1) && pos_reg <= POS_W'(count_reg)))
        else $error("sift position outside the heap");

    a_empty_extract: assert property (@(posedge clk) disable iff (!rst_n)
        (in_xfer && s_tuser == mhpq_pkg::CMD_EXTRACT && count_reg == '0)
        |=> (state_reg == mhpq_pkg::ST_DONE && res_status_reg == mhpq_pkg::STATUS_EMPTY
             && count_reg == '0))
        else $error("extract from empty heap not reported");

    a_write_in_sift: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> (state_reg == mhpq_pkg::ST_UP_RD || state_reg == mhpq_pkg::ST_UP_CMP
                    || state_reg == mhpq_pkg::ST_DN_CMP))
        else $error("heap write outside a sift");
`endif

endmodule
